FILE: rtl/cassinian_oval_torus_point_unit_assert.svh
// Assertion macros shared by the Cassinian-oval torus point unit.
`ifndef CASSINIAN_OVAL_TORUS_POINT_UNIT_ASSERT_SVH
`define CASSINIAN_OVAL_TORUS_POINT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define COT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define COT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define COT_ASSERT(lbl, clk, rst_n, prop)
`define COT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/cot_pkg.sv
// Shared types, constants and helper functions of the torus point unit.
`timescale 1ns / 1ps
package cot_pkg;
	localparam int unsigned ANGLE_BITS_DEF = 16;
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned IN_DATA_W = 32;
	localparam int unsigned COORD_W = 24;
	localparam int unsigned OUT_DATA_W = 72;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TRIG_W = 32;
	localparam int unsigned CORDIC_W = 34;
	localparam int unsigned CORDIC_STEPS = 24;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [FIELD_W-1:0] CFG_RESET = 16'd4096;
	localparam logic signed [63:0] OUT_MAX = 64'sd8388607;
	localparam logic signed [63:0] OUT_MIN = -64'sd8388608;
	localparam logic signed [63:0] ROUND_HALF = 64'sd8589934592;

	localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;
	typedef enum logic [CFG_IDX_W-1:0] {CFG_RADIUS_MAJOR, CFG_OVAL_A, CFG_OVAL_B} cfg_idx_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cu;
		logic signed [TRIG_W-1:0] su;
		logic signed [TRIG_W-1:0] cv;
		logic signed [TRIG_W-1:0] sv;
	} trig_t;

	typedef struct packed {
		logic undef;
		logic signed [29:0] p;
		trig_t trig;
	} sq1_sb_t;

	typedef struct packed {
		logic undef;
		trig_t trig;
	} sq2_sb_t;

	typedef struct packed {
		logic undefined_point;
		logic signed [COORD_W-1:0] z_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] x_coord;
	} point_t;

	// Rounds a Q.50 product half up to Q8.16 and clamps it to the 24-bit range.
	function automatic logic signed [COORD_W-1:0] cot_round_sat(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + ROUND_HALF) >>> 34;
		if (r > OUT_MAX) begin
			r = OUT_MAX;
		end else if (r < OUT_MIN) begin
			r = OUT_MIN;
		end
		return COORD_W'(r);
	endfunction
endpackage

FILE: rtl/cassinian_oval_torus_point_unit.sv
// Top level of the Cassinian-oval torus point unit: pipeline, config and output buffer.
`timescale 1ns / 1ps
// This unit takes a request of two surface angles u and v (2^ANGLE_BITS is one full turn)
// and returns one point of a torus whose cross-section is a Cassini oval, with
// x = (R + M sin v) cos u, y = (R + M sin v) sin u and z = M cos v in signed Q8.16,
// saturated. It accepts one request per clock cycle and delivers one result per cycle
// in order while the output is not stalled. The pipeline is made of the three parallel
// 25-stage CORDIC units, the two square-root pipelines (29 and 25 stages, one root bit
// each) and eight arithmetic stages. Whenever the square-root argument would be
// negative the result carries the undefined flag in tuser and all three coordinates
// are zero. An output register with a one-entry skid buffer sits behind the pipeline,
// so the unit keeps taking requests while one finished result waits; tready drops
// only when the skid entry is also full. The registers R, a and b (unsigned Q4.12)
// are written through the cfg port and must only change while no request is in
// flight.
module cassinian_oval_torus_point_unit #(
	parameter int unsigned ANGLE_BITS = cot_pkg::ANGLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// Fields from bit 0: angle_u[15:0], angle_v[31:16].
	input  logic [cot_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0: x_coord[23:0], y_coord[47:24], z_coord[71:48].
	output logic [cot_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// Fields from bit 0: undefined_point[0].
	output logic [0:0]                        m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [cot_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cot_pkg::FIELD_W-1:0]       cfg_data
);
	import cot_pkg::*;

	// Configuration registers and the values derived from them.
	logic [FIELD_W-1:0] radius_major_q;
	logic [FIELD_W-1:0] oval_a_q;
	logic [FIELD_W-1:0] oval_b_q;
	logic [27:0] a_sq_q;
	logic [27:0] b_sq_q;
	logic [55:0] aa_q;
	logic [55:0] bb_q;
	logic signed [57:0] d_q;

	logic en;
	logic [FIELD_W-1:0] angle_u;
	logic [FIELD_W-1:0] angle_v;
	logic [ANGLE_BITS-1:0] ang_u;
	logic [ANGLE_BITS-1:0] ang_v;
	logic [ANGLE_BITS-1:0] ang_w;

	logic vld_u;
	logic vld_v;
	logic vld_w;
	logic signed [TRIG_W-1:0] cu_c;
	logic signed [TRIG_W-1:0] su_c;
	logic signed [TRIG_W-1:0] cv_c;
	logic signed [TRIG_W-1:0] sv_c;
	logic signed [TRIG_W-1:0] c2_c;
	logic signed [TRIG_W-1:0] s2_c;

	logic signed [60:0] ap_c;
	logic vld_s1;
	logic signed [29:0] p_s1;
	trig_t trig_s1;

	logic signed [59:0] pp_c;
	logic vld_s2;
	logic signed [29:0] p_s2;
	logic signed [59:0] pp_s2;
	trig_t trig_s2;

	logic signed [57:0] rad1_c;
	logic vld_s3;
	logic [57:0] rad1_s3;
	sq1_sb_t sb1_s3;

	logic sq1_vld;
	logic [28:0] s_root;
	sq1_sb_t sb1_out;

	logic signed [30:0] rad2_c;
	logic undef4_c;
	logic vld_s4;
	logic [49:0] rad2_s4;
	sq2_sb_t sb2_s4;

	logic sq2_vld;
	logic [24:0] m_root;
	sq2_sb_t sb2_out;

	logic signed [57:0] msv_c;
	logic signed [57:0] mcv_c;
	logic vld_s5;
	logic signed [57:0] msv_s5;
	logic signed [57:0] mcv_s5;
	logic signed [TRIG_W-1:0] cu_s5;
	logic signed [TRIG_W-1:0] su_s5;
	logic undef_s5;

	logic signed [27:0] factor_c;
	logic vld_s6;
	logic signed [27:0] factor_s6;
	logic signed [COORD_W-1:0] z_s6;
	logic signed [TRIG_W-1:0] cu_s6;
	logic signed [TRIG_W-1:0] su_s6;
	logic undef_s6;

	logic vld_s7;
	logic signed [59:0] xp_s7;
	logic signed [59:0] yp_s7;
	logic signed [COORD_W-1:0] z_s7;
	logic undef_s7;

	logic vld_s8;
	point_t pt_s8;

	logic out_vld_q;
	point_t out_q;
	logic sk_vld_q;
	point_t sk_q;

	// Configuration writes; an index past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_major_q <= CFG_RESET;
			oval_a_q <= CFG_RESET;
			oval_b_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RADIUS_MAJOR: radius_major_q <= cfg_data;
				CFG_OVAL_A:       oval_a_q <= cfg_data;
				CFG_OVAL_B:       oval_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A = a^2 and B = b^2 in Q8.20, then B^2 - A^2 in Q16.40. These are registered in
	// turn after a write and settle long before any request reaches the point of use.
	always_ff @(posedge clk) begin
		a_sq_q <= 28'((32'(oval_a_q) * 32'(oval_a_q)) >> 4);
		b_sq_q <= 28'((32'(oval_b_q) * 32'(oval_b_q)) >> 4);
		aa_q <= 56'(a_sq_q) * 56'(a_sq_q);
		bb_q <= 56'(b_sq_q) * 56'(b_sq_q);
		d_q <= $signed({2'b00, bb_q}) - $signed({2'b00, aa_q});
	end

	// The whole pipeline moves unless the skid entry is occupied.
	assign en = !sk_vld_q;
	assign s_axis_tready = en;

	assign angle_u = s_axis_tdata[FIELD_W-1:0];
	assign angle_v = s_axis_tdata[2*FIELD_W-1:FIELD_W];
	assign ang_u = ANGLE_BITS'({{ANGLE_BITS{1'b0}}, angle_u});
	assign ang_v = ANGLE_BITS'({{ANGLE_BITS{1'b0}}, angle_v});
	// Doubling the angle wraps modulo one full turn.
	assign ang_w = ANGLE_BITS'({ang_v, 1'b0});

	cot_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_u (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_axis_tvalid),
		.angle(ang_u), .out_vld(vld_u), .cos_val(cu_c), .sin_val(su_c)
	);

	cot_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_axis_tvalid),
		.angle(ang_v), .out_vld(vld_v), .cos_val(cv_c), .sin_val(sv_c)
	);

	cot_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_w (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_axis_tvalid),
		.angle(ang_w), .out_vld(vld_w), .cos_val(c2_c), .sin_val(s2_c)
	);

	// Stage 1: P = A*cos(2v), floored back to Q8.20. sin(2v) is not needed.
	assign ap_c = $signed({1'b0, a_sq_q}) * c2_c;

	// Stage 2: P squared.
	assign pp_c = p_s1 * p_s1;

	// Stage 3: inner radicand B^2 - A^2 + P^2; a negative value marks the point undefined.
	// P^2 stays below 2^57, so the low 58 bits of it carry the full value.
	assign rad1_c = d_q + 58'(pp_s2);

	// Stage 4: outer radicand P + S, moved to Q.40 so that its root is in Q.20.
	assign rad2_c = 31'(sb1_out.p) + $signed({2'b00, s_root});
	assign undef4_c = sb1_out.undef || rad2_c[30];

	// Stage 5: M*sin v and M*cos v.
	assign msv_c = $signed({1'b0, m_root}) * sb2_out.trig.sv;
	assign mcv_c = $signed({1'b0, m_root}) * sb2_out.trig.cv;

	// Stage 6: factor = R + M*sin v, with R widened to Q.20.
	assign factor_c = $signed({4'b0000, radius_major_q, 8'h00}) + 28'(msv_s5 >>> 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_u;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= sq1_vld;
			vld_s5 <= sq2_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= 30'(ap_c >>> 30);
			trig_s1 <= '{cu: cu_c, su: su_c, cv: cv_c, sv: sv_c};

			p_s2 <= p_s1;
			pp_s2 <= pp_c;
			trig_s2 <= trig_s1;

			rad1_s3 <= rad1_c[57] ? '0 : 58'(rad1_c);
			sb1_s3 <= '{undef: rad1_c[57], p: p_s2, trig: trig_s2};

			rad2_s4 <= undef4_c ? '0 : {rad2_c[29:0], 20'h00000};
			sb2_s4 <= '{undef: undef4_c, trig: sb1_out.trig};

			msv_s5 <= msv_c;
			mcv_s5 <= mcv_c;
			cu_s5 <= sb2_out.trig.cu;
			su_s5 <= sb2_out.trig.su;
			undef_s5 <= sb2_out.undef;

			factor_s6 <= factor_c;
			z_s6 <= cot_round_sat(64'(mcv_s5));
			cu_s6 <= cu_s5;
			su_s6 <= su_s5;
			undef_s6 <= undef_s5;

			xp_s7 <= factor_s6 * cu_s6;
			yp_s7 <= factor_s6 * su_s6;
			z_s7 <= z_s6;
			undef_s7 <= undef_s6;

			pt_s8.x_coord <= undef_s7 ? '0 : cot_round_sat(64'(xp_s7));
			pt_s8.y_coord <= undef_s7 ? '0 : cot_round_sat(64'(yp_s7));
			pt_s8.z_coord <= undef_s7 ? '0 : z_s7;
			pt_s8.undefined_point <= undef_s7;
		end
	end

	cot_isqrt #(.IN_W(58), .SB_W($bits(sq1_sb_t))) u_sqrt_inner (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.rad(rad1_s3), .sb_in(sb1_s3),
		.out_vld(sq1_vld), .root(s_root), .sb_out(sb1_out)
	);

	cot_isqrt #(.IN_W(50), .SB_W($bits(sq2_sb_t))) u_sqrt_outer (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s4),
		.rad(rad2_s4), .sb_in(sb2_s4),
		.out_vld(sq2_vld), .root(m_root), .sb_out(sb2_out)
	);

	// Output register plus one skid entry. A point leaving the pipeline while the
	// output register is held goes to the skid entry, which then stalls the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q <= 1'b0;
		end else if (en) begin
			if (vld_s8 && out_vld_q && !m_axis_tready) begin
				sk_vld_q <= 1'b1;
			end else if (vld_s8) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end else if (m_axis_tready) begin
			sk_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (vld_s8 && out_vld_q && !m_axis_tready) begin
				sk_q <= pt_s8;
			end else if (vld_s8) begin
				out_q <= pt_s8;
			end
		end else if (m_axis_tready) begin
			out_q <= sk_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {out_q.z_coord, out_q.y_coord, out_q.x_coord};
	assign m_axis_tuser = out_q.undefined_point;

	`include "cassinian_oval_torus_point_unit_assert.svh"

	`COT_ASSERT(a_skid_needs_out, clk, arst_n, sk_vld_q |-> out_vld_q)
	`COT_ASSERT(a_lanes_agree, clk, arst_n, (vld_u == vld_v) && (vld_u == vld_w))
	`COT_ASSERT(a_undef_zero, clk, arst_n, (out_vld_q && out_q.undefined_point) |-> ((out_q.x_coord == '0) && (out_q.y_coord == '0) && (out_q.z_coord == '0)))
	`COT_ASSERT_NEXT(a_skid_holds, clk, arst_n, sk_vld_q && !m_axis_tready, sk_vld_q && out_vld_q)
endmodule

FILE: rtl/cot_cordic.sv
// Pipelined CORDIC that turns a turn-scaled angle into Q2.30 cosine and sine.
`timescale 1ns / 1ps
module cot_cordic #(
	parameter int unsigned ANGLE_BITS = cot_pkg::ANGLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic [ANGLE_BITS-1:0]                 angle,
	output logic                                  out_vld,
	output logic signed [cot_pkg::TRIG_W-1:0]     cos_val,
	output logic signed [cot_pkg::TRIG_W-1:0]     sin_val
);
	import cot_pkg::*;

	localparam int unsigned QW = ANGLE_BITS - 2;

	logic [QW-1:0] frac;
	quad_t quad;
	logic [QW+30:0] zprod;
	logic signed [CORDIC_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] z_s [CORDIC_STEPS+1];
	quad_t q_s [CORDIC_STEPS+1];
	logic vld_s [CORDIC_STEPS+1];

	assign frac = angle[QW-1:0];
	assign quad = quad_t'(angle[ANGLE_BITS-1 -: 2]);
	// The angle inside the quadrant becomes radians in Q2.30, truncated.
	assign zprod = (QW+31)'(frac) * (QW+31)'(HALF_PI_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN_Q30;
			y_s[0] <= '0;
			z_s[0] <= $signed(CORDIC_W'(zprod >> QW));
			q_s[0] <= quad;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CORDIC_W-1:0] xs;
		logic signed [CORDIC_W-1:0] ys;
		logic signed [CORDIC_W-1:0] atan_v;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign atan_v = $signed({2'b00, ATAN_Q30[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - atan_v;
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + atan_v;
				end
			end
		end
	end

	assign out_vld = vld_s[CORDIC_STEPS];

	// Fold the first-quadrant result back to the quadrant of the angle.
	always_comb begin
		unique case (q_s[CORDIC_STEPS])
			QUAD_I: begin
				cos_val = TRIG_W'(x_s[CORDIC_STEPS]);
				sin_val = TRIG_W'(y_s[CORDIC_STEPS]);
			end
			QUAD_II: begin
				cos_val = TRIG_W'(-y_s[CORDIC_STEPS]);
				sin_val = TRIG_W'(x_s[CORDIC_STEPS]);
			end
			QUAD_III: begin
				cos_val = TRIG_W'(-x_s[CORDIC_STEPS]);
				sin_val = TRIG_W'(-y_s[CORDIC_STEPS]);
			end
			QUAD_IV: begin
				cos_val = TRIG_W'(y_s[CORDIC_STEPS]);
				sin_val = TRIG_W'(-x_s[CORDIC_STEPS]);
			end
		endcase
	end
endmodule

FILE: rtl/cot_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side channel.
`timescale 1ns / 1ps
module cot_isqrt #(
	parameter int unsigned IN_W = 58,
	parameter int unsigned SB_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [IN_W-1:0]     rad,
	input  logic [SB_W-1:0]     sb_in,
	output logic                out_vld,
	output logic [IN_W/2-1:0]   root,
	output logic [SB_W-1:0]     sb_out
);
	localparam int unsigned N = IN_W / 2;
	localparam int unsigned RW = N + 3;

	logic [RW-1:0] rem_s [1:N];
	logic [N-1:0] root_s [1:N];
	logic [IN_W-1:0] rad_s [1:N];
	logic [SB_W-1:0] sb_s [1:N];
	logic vld_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_digit
		logic [RW-1:0] rem_i;
		logic [N-1:0] root_i;
		logic [IN_W-1:0] rad_i;
		logic [SB_W-1:0] sb_i;
		logic vld_i;
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic ge;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign root_i = '0;
			assign rad_i = rad;
			assign sb_i = sb_in;
			assign vld_i = in_vld;
		end else begin : g_rest
			assign rem_i = rem_s[k];
			assign root_i = root_s[k];
			assign rad_i = rad_s[k];
			assign sb_i = sb_s[k];
			assign vld_i = vld_s[k];
		end

		// Bring down the next two radicand bits and try root*4+1.
		assign rem_sh = {rem_i[RW-3:0], rad_i[IN_W-1 -: 2]};
		assign trial = RW'({root_i, 2'b01});
		assign ge = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_i[N-2:0], ge};
				rad_s[k+1] <= rad_i << 2;
				sb_s[k+1] <= sb_i;
			end
		end
	end

	assign out_vld = vld_s[N];
	assign root = root_s[N];
	assign sb_out = sb_s[N];
endmodule
